// ===== hw/rtl/greedy_word_wrap_top_macros.svh =====
// Assertion macros for the greedy word wrap block.
// Used by greedy_word_wrap_top; depends on nothing else.
`ifndef GREEDY_WORD_WRAP_TOP_MACROS_SVH
`define GREEDY_WORD_WRAP_TOP_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define GWW_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the next cycle.
`define GWW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/gww_pkg.sv =====
// Shared constants, state and command types of the greedy word wrap block.
// Used by gww_control, gww_datapath and greedy_word_wrap_top; no dependencies.
package gww_pkg;

   localparam int MAX_WIDTH = 62;
   localparam int LEN_BITS  = 6;

   localparam logic [LEN_BITS-1:0] RESET_LINE_WIDTH = LEN_BITS'(40);
   localparam logic [LEN_BITS-1:0] MAX_LEN          = LEN_BITS'(MAX_WIDTH);

   localparam logic [7:0] CHAR_NONE  = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_PARA1,
      ST_PARA2,
      ST_CHECK,
      ST_PLACE_SEP,
      ST_PLACE_WORD,
      ST_END_TAIL
   } state_type;

   typedef enum logic [1:0] {
      EMIT_SEP,
      EMIT_WORD,
      EMIT_NL,
      EMIT_STATUS
   } emit_sel_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic         latch_in;
      logic         nl_count;
      logic         run_clear;
      logic         store;
      logic         place_sep;
      logic         word_adv;
      logic         line_zero;
      logic         text_clear;
      logic         set_abort;
      logic         emit;
      emit_sel_type sel;
      logic         err;
      logic         done;
      logic         last;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic abort;
      logic cur_end;
      logic is_zero;
      logic is_sep;
      logic is_nl;
      logic word_empty;
      logic line_empty;
      logic para;
      logic too_long;
      logic word_final;
      logic out_free;
   } status_type;

endpackage

// ===== hw/rtl/gww_datapath.sv =====
// Datapath of the greedy word wrap block: word buffer, lengths, width register
// and result register. Depends on gww_pkg; driven by gww_control.
module gww_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [7:0]                    req_tdata,
   input  logic                          req_tlast,
   input  logic                          csr_wr_en,
   input  logic [gww_pkg::LEN_BITS-1:0]  csr_wr_data,
   input  gww_pkg::cmd_type              cmd,
   output gww_pkg::status_type           status,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,
   output logic [2:0]                    rsp_tuser,
   output logic                          rsp_tlast
);

   logic [gww_pkg::LEN_BITS-1:0] line_width_ff;
   logic [7:0]                   cur_byte_ff;
   logic                         cur_end_ff;
   logic [gww_pkg::LEN_BITS-1:0] word_length_ff, word_length_in;
   logic [gww_pkg::LEN_BITS-1:0] line_length_ff, line_length_in;
   logic [1:0]                   newline_run_ff, newline_run_in;
   logic                         abort_ff, abort_in;
   logic [gww_pkg::LEN_BITS-1:0] idx_ff, idx_in;
   logic [7:0]                   rd_ff;
   logic [7:0]                   word_mem [0:gww_pkg::MAX_WIDTH-1];
   logic                         rsp_valid_ff;
   logic [7:0]                   rsp_byte_ff;
   logic [2:0]                   rsp_user_ff;
   logic                         rsp_last_ff;

   logic [gww_pkg::LEN_BITS-1:0] eff_width;
   logic [gww_pkg::LEN_BITS:0]   fit_sum;
   logic                         fits;
   logic [gww_pkg::LEN_BITS:0]   line_sum;
   logic [gww_pkg::LEN_BITS-1:0] line_sat;
   logic                         out_free;
   logic [7:0]                   emit_byte;
   logic                         emit_valid;

   // Clamp the configured width into 1..MAX_WIDTH
   always_comb begin
      if (line_width_ff == '0) begin
         eff_width = gww_pkg::LEN_BITS'(1);
      end else if (line_width_ff > gww_pkg::MAX_LEN) begin
         eff_width = gww_pkg::MAX_LEN;
      end else begin
         eff_width = line_width_ff;
      end
   end

   // Fit test for a word after one space, and the line length after a word
   assign fit_sum  = {1'b0, line_length_ff} + (gww_pkg::LEN_BITS+1)'(1)
                     + {1'b0, word_length_ff};
   assign fits     = fit_sum <= {1'b0, eff_width};
   assign line_sum = {1'b0, line_length_ff} + {1'b0, word_length_ff};
   assign line_sat = (line_sum > {1'b0, gww_pkg::MAX_LEN}) ? gww_pkg::MAX_LEN
                                                           : line_sum[gww_pkg::LEN_BITS-1:0];

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Status toward the controller
   always_comb begin
      status.abort      = abort_ff;
      status.cur_end    = cur_end_ff;
      status.is_zero    = cur_byte_ff == gww_pkg::CHAR_NONE;
      status.is_nl      = cur_byte_ff == gww_pkg::CHAR_NL;
      status.is_sep     = (cur_byte_ff == gww_pkg::CHAR_SPACE) ||
                          (cur_byte_ff == gww_pkg::CHAR_TAB) ||
                          (cur_byte_ff == gww_pkg::CHAR_NL);
      status.word_empty = word_length_ff == '0;
      status.line_empty = line_length_ff == '0;
      status.para       = (newline_run_ff == 2'd2) && (line_length_ff != '0);
      status.too_long   = word_length_ff >= eff_width;
      status.word_final = idx_ff == (word_length_ff - gww_pkg::LEN_BITS'(1));
      status.out_free   = out_free;
   end

   // Next values of the text state
   always_comb begin
      word_length_in = word_length_ff;
      line_length_in = line_length_ff;
      newline_run_in = newline_run_ff;
      abort_in       = abort_ff;
      idx_in         = idx_ff;
      if (cmd.nl_count && (newline_run_ff != 2'd2)) begin
         newline_run_in = newline_run_ff + 2'd1;
      end
      if (cmd.run_clear) begin
         newline_run_in = '0;
      end
      if (cmd.line_zero) begin
         line_length_in = '0;
      end
      if (cmd.place_sep) begin
         line_length_in = fits ? line_length_ff + gww_pkg::LEN_BITS'(1) : '0;
      end
      if (cmd.store) begin
         word_length_in = word_length_ff + gww_pkg::LEN_BITS'(1);
      end
      if (cmd.word_adv) begin
         if (status.word_final) begin
            idx_in         = '0;
            word_length_in = '0;
            line_length_in = line_sat;
         end else begin
            idx_in = idx_ff + gww_pkg::LEN_BITS'(1);
         end
      end
      if (cmd.set_abort) begin
         abort_in = 1'b1;
      end
      if (cmd.text_clear) begin
         word_length_in = '0;
         line_length_in = '0;
         newline_run_in = '0;
         abort_in       = 1'b0;
         idx_in         = '0;
      end
   end

   // Control registers of the text state and width
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff  <= gww_pkg::RESET_LINE_WIDTH;
         word_length_ff <= '0;
         line_length_ff <= '0;
         newline_run_ff <= '0;
         abort_ff       <= 1'b0;
         idx_ff         <= '0;
      end else begin
         if (csr_wr_en) begin
            line_width_ff <= csr_wr_data;
         end
         word_length_ff <= word_length_in;
         line_length_ff <= line_length_in;
         newline_run_ff <= newline_run_in;
         abort_ff       <= abort_in;
         idx_ff         <= idx_in;
      end
   end

   // Hold the current input transaction
   always_ff @(posedge clock) begin
      if (cmd.latch_in) begin
         cur_byte_ff <= req_tdata;
         cur_end_ff  <= req_tlast;
      end
   end

   // Word buffer: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         word_mem[word_length_ff] <= cur_byte_ff;
      end
      rd_ff <= word_mem[idx_in];
   end

   // Select the emitted character
   always_comb begin
      emit_valid = 1'b1;
      case (cmd.sel)
         gww_pkg::EMIT_SEP:  emit_byte = fits ? gww_pkg::CHAR_SPACE : gww_pkg::CHAR_NL;
         gww_pkg::EMIT_WORD: emit_byte = rd_ff;
         gww_pkg::EMIT_NL:   emit_byte = gww_pkg::CHAR_NL;
         default: begin
            emit_byte  = gww_pkg::CHAR_NONE;
            emit_valid = 1'b0;
         end
      endcase
   end

   // Result register: load on emit, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_byte_ff <= emit_byte;
         rsp_user_ff <= {cmd.done, cmd.err, emit_valid};
         rsp_last_ff <= cmd.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hw/rtl/gww_control.sv =====
// Controller state machine of the greedy word wrap block.
// Depends on gww_pkg; sequences gww_datapath through command and status.
module gww_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  gww_pkg::status_type status,
   output gww_pkg::cmd_type    cmd
);

   gww_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gww_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.sel    = gww_pkg::EMIT_STATUS;
      unique case (state_ff)
         gww_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch_in = 1'b1;
               state_in     = gww_pkg::ST_DECIDE;
            end
         end
         gww_pkg::ST_DECIDE: begin
            if (status.abort) begin
               // Aborted text: only the end transaction reports
               if (!status.cur_end) begin
                  state_in = gww_pkg::ST_IDLE;
               end else if (status.out_free) begin
                  cmd.emit       = 1'b1;
                  cmd.err        = 1'b1;
                  cmd.done       = 1'b1;
                  cmd.last       = 1'b1;
                  cmd.text_clear = 1'b1;
                  state_in       = gww_pkg::ST_IDLE;
               end
            end else if (status.is_zero) begin
               state_in = status.cur_end ? gww_pkg::ST_PLACE_SEP : gww_pkg::ST_IDLE;
            end else if (status.is_sep) begin
               cmd.nl_count = status.is_nl;
               state_in     = gww_pkg::ST_PLACE_SEP;
            end else if (status.word_empty) begin
               cmd.run_clear = 1'b1;
               state_in      = status.para ? gww_pkg::ST_PARA1 : gww_pkg::ST_CHECK;
            end else begin
               state_in = gww_pkg::ST_CHECK;
            end
         end
         gww_pkg::ST_PARA1: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = gww_pkg::EMIT_NL;
               state_in = gww_pkg::ST_PARA2;
            end
         end
         gww_pkg::ST_PARA2: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.sel       = gww_pkg::EMIT_NL;
               cmd.last      = !status.too_long && !status.cur_end;
               cmd.line_zero = 1'b1;
               state_in      = gww_pkg::ST_CHECK;
            end
         end
         gww_pkg::ST_CHECK: begin
            if (status.too_long) begin
               // Word overflows the line: report and abort the text
               if (status.out_free) begin
                  cmd.emit       = 1'b1;
                  cmd.err        = 1'b1;
                  cmd.done       = status.cur_end;
                  cmd.last       = 1'b1;
                  cmd.text_clear = status.cur_end;
                  cmd.set_abort  = !status.cur_end;
                  state_in       = gww_pkg::ST_IDLE;
               end
            end else begin
               cmd.store = 1'b1;
               state_in  = status.cur_end ? gww_pkg::ST_PLACE_SEP : gww_pkg::ST_IDLE;
            end
         end
         gww_pkg::ST_PLACE_SEP: begin
            if (status.word_empty) begin
               state_in = status.cur_end ? gww_pkg::ST_END_TAIL : gww_pkg::ST_IDLE;
            end else if (status.line_empty) begin
               state_in = gww_pkg::ST_PLACE_WORD;
            end else if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.sel       = gww_pkg::EMIT_SEP;
               cmd.place_sep = 1'b1;
               state_in      = gww_pkg::ST_PLACE_WORD;
            end
         end
         gww_pkg::ST_PLACE_WORD: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.sel      = gww_pkg::EMIT_WORD;
               cmd.word_adv = 1'b1;
               cmd.last     = status.word_final && !status.cur_end;
               if (status.word_final) begin
                  state_in = status.cur_end ? gww_pkg::ST_END_TAIL : gww_pkg::ST_IDLE;
               end
            end
         end
         gww_pkg::ST_END_TAIL: begin
            // Close an open line, or report an empty text
            if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.sel        = status.line_empty ? gww_pkg::EMIT_STATUS
                                                  : gww_pkg::EMIT_NL;
               cmd.done       = 1'b1;
               cmd.last       = 1'b1;
               cmd.text_clear = 1'b1;
               state_in       = gww_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gww_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/greedy_word_wrap_top.sv =====
// Greedy word wrap: reflows a byte stream to a set line width, one input
// transaction at a time, producing zero or more result transactions per byte.
// An input transaction is accepted in ST_IDLE and decoded in the next cycle; a
// zero byte ends there, and a word character is then checked and stored. A
// separator, or any transaction that ends the text, then places the buffered
// word: ST_PLACE_SEP emits the space or newline ahead of the word when the line
// is open, and ST_PLACE_WORD emits the word characters, read back one per cycle
// from the word buffer while the result register is free. The end of a text
// adds the closing newline or status transaction, and a paragraph break adds
// two newlines. Any cycle that emits waits while the result register is held by
// rsp_tready low. The word buffer needs no clearing after reset, so the block
// takes input from the first cycle after reset.
// Depends on gww_pkg, gww_control, gww_datapath and the macro header.
`include "greedy_word_wrap_top_macros.svh"

module greedy_word_wrap_top (
   input  logic                         clock,
   input  logic                         reset,
   // Input channel
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // [7:0] text_byte
   input  logic                         req_tlast,   // end_of_text
   // Result channel
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata,   // [7:0] out_byte
   output logic [2:0]                   rsp_tuser,   // [0] byte_valid, [1] word_too_long,
                                                     // [2] text_done
   output logic                         rsp_tlast,   // run_last
   // Line width register
   input  logic                         csr_wr_en,
   input  logic [gww_pkg::LEN_BITS-1:0] csr_wr_data
);

   gww_pkg::cmd_type    cmd;
   gww_pkg::status_type status;

   gww_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gww_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   // One input transaction is worked on at a time
   `GWW_ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready, "input accepted while busy")
   // The end of a text always closes the run of its input transaction
   `GWW_ASSERT_SAME(a_done_last, clock, reset, rsp_tvalid && rsp_tuser[2], rsp_tlast, "text_done without run_last")
   // An overflow report carries no character
   `GWW_ASSERT_SAME(a_err_status, clock, reset, rsp_tvalid && rsp_tuser[1], !rsp_tuser[0], "word_too_long with a character")

endmodule
